// File: rtl/asvs_pkg.sv
// Shared constants, types and the sine table generator for the additive sine synth.
`default_nettype none

package asvs_pkg;

    // core sizing
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int MAX_HARMONICS  = 8;

    // quarter-wave table
    localparam int QWAVE     = 1 << SINE_ADDR_BITS;
    localparam int ROM_DEPTH = QWAVE + 1;
    localparam int ROM_AW    = SINE_ADDR_BITS + 1;
    localparam int SINE_W    = 15;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

    // harmonic bookkeeping
    localparam int GAIN_HARMONICS = 8;
    localparam int HIDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int HCNT_W = $clog2(MAX_HARMONICS + 1);

    // datapath widths
    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = 16;
    localparam int MUL_PW  = MUL_AW + 1 + MUL_BW;
    localparam int AG_W    = 15 + 8;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = AG_W + MUL_BW + $clog2(MAX_HARMONICS) + 1;
    localparam int SUM_SHIFT = 22;
    localparam int DEV_SHIFT = 15;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // configuration port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [31:0] RST_BASE_INC  = 32'd42852282;
    localparam logic [31:0] RST_VIB_RATE  = 32'd0;
    localparam logic [30:0] RST_VIB_DEPTH = 31'd0;
    localparam logic [14:0] RST_AMPLITUDE = 15'd1000;
    localparam logic [63:0] RST_GAINS     = 64'd128;
    localparam logic [3:0]  RST_HARM_CNT  = 4'd8;

    typedef enum logic [2:0] {
        REG_BASE_INC   = 3'd0,
        REG_VIB_RATE   = 3'd1,
        REG_VIB_DEPTH  = 3'd2,
        REG_AMPLITUDE  = 3'd3,
        REG_GAINS      = 3'd4,
        REG_HARM_COUNT = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_HARM_ISSUE,
        OP_HARM_MUL,
        OP_ACC_LAST,
        OP_VIB_ISSUE,
        OP_VIB_MUL,
        OP_CAR_ADV,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_H_ISSUE,
        ST_H_MUL,
        ST_H_LAST,
        ST_V_ISSUE,
        ST_V_MUL,
        ST_C_ADV,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [HIDX_W-1:0] harm_idx;
    } cmd_t;

    typedef struct packed {
        logic [31:0] base_inc;
        logic [31:0] vib_rate;
        logic [30:0] vib_depth;
        logic [14:0] amplitude;
        logic [63:0] gains;
    } cfg_t;

    // round(32767 * sin(pi/2 * k/QWAVE)), Taylor series in Q30
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          v;
        x    = (HALFPI_Q30 * longint'(k)) >> SINE_ADDR_BITS;
        term = x;
        sum  = longint'(x);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 6;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 20;
        sum  = sum + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 42;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 72;
        sum  = sum + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 110;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
        if (v > 32767)
        begin
            v = 32767;
        end
        return SINE_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/asvs_sine_rom.sv
// Quarter-wave sine ROM with registered read.
`default_nettype none

module asvs_sine_rom (
    input  wire logic                          clk,
    input  wire logic [asvs_pkg::ROM_AW-1:0]   addr,
    output logic      [asvs_pkg::SINE_W-1:0]   rom_q
);

    logic [asvs_pkg::SINE_W-1:0] rom_mem [asvs_pkg::ROM_DEPTH];
    logic [asvs_pkg::SINE_W-1:0] rom_q_reg;

    for (genvar gi = 0; gi < asvs_pkg::ROM_DEPTH; gi++)
    begin : g_rom
        assign rom_mem[gi] = asvs_pkg::sine_entry(gi);
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= rom_mem[addr];
    end

    assign rom_q = rom_q_reg;

endmodule

`default_nettype wire

// File: rtl/asvs_datapath.sv
// Datapath: phase accumulators, shared multiplier, harmonic accumulator, output register.
`default_nettype none

module asvs_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire asvs_pkg::cmd_t       cmd,
    input  wire asvs_pkg::cfg_t       cfg,
    input  wire logic                 restart,
    output logic signed [15:0]        sample
);

    localparam int PB = asvs_pkg::PHASE_BITS;

    logic [PB-1:0]                     carrier_reg, carrier_next;
    logic [PB-1:0]                     vib_reg, vib_next;
    logic [PB-1:0]                     hphase_reg, hphase_next;
    logic                              neg_reg, neg_next;
    logic [asvs_pkg::AG_W-1:0]         ag_reg, ag_next;
    logic signed [asvs_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [asvs_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [15:0]                res_reg, res_next;
    logic signed [15:0]                sample_reg, sample_next;

    logic [PB-1:0]                     rd_phase;
    logic [1:0]                        quad;
    logic [asvs_pkg::SINE_ADDR_BITS-1:0] qaddr;
    logic [asvs_pkg::ROM_AW-1:0]       rom_addr;
    logic [asvs_pkg::SINE_W-1:0]       rom_q;
    logic signed [15:0]                sine;
    logic [7:0]                        gain;
    logic [asvs_pkg::MUL_AW-1:0]       mul_a;
    logic signed [asvs_pkg::MUL_BW-1:0] mul_b;
    logic signed [asvs_pkg::MUL_PW-1:0] mul_p;
    logic signed [asvs_pkg::ACC_W-1:0]  acc_rnd;
    logic signed [asvs_pkg::ACC_W-1:0]  acc_q;
    logic signed [asvs_pkg::PROD_W-1:0] dev_rnd;
    logic signed [asvs_pkg::PROD_W-1:0] dev;

    asvs_sine_rom u_rom (
        .clk   (clk),
        .addr  (rom_addr),
        .rom_q (rom_q)
    );

    // table lookup: quadrant folds the address, sign applied after the read
    assign rd_phase = (cmd.op == asvs_pkg::OP_VIB_ISSUE) ? vib_reg : hphase_reg;
    assign quad     = rd_phase[PB-1 -: 2];
    assign qaddr    = rd_phase[PB-3 -: asvs_pkg::SINE_ADDR_BITS];
    assign rom_addr = quad[0] ? (asvs_pkg::ROM_AW'(asvs_pkg::QWAVE) - {1'b0, qaddr})
                              : {1'b0, qaddr};
    assign sine     = neg_reg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

    always_comb
    begin
        gain = 8'd0;
        for (int k = 0; k < asvs_pkg::GAIN_HARMONICS; k++)
        begin
            if (int'(cmd.harm_idx) == k)
            begin
                gain = cfg.gains[8*k +: 8];
            end
        end
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.op)
            asvs_pkg::OP_HARM_ISSUE:
            begin
                mul_a = asvs_pkg::MUL_AW'(cfg.amplitude);
                mul_b = $signed({8'd0, gain});
            end
            asvs_pkg::OP_HARM_MUL:
            begin
                mul_a = asvs_pkg::MUL_AW'(ag_reg);
                mul_b = sine;
            end
            asvs_pkg::OP_VIB_MUL:
            begin
                mul_a = asvs_pkg::MUL_AW'(cfg.vib_depth);
                mul_b = sine;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // sum / 2^22 truncated toward zero
    assign acc_rnd = acc_reg + ((acc_reg < 0)
                     ? asvs_pkg::ACC_W'((1 << asvs_pkg::SUM_SHIFT) - 1)
                     : asvs_pkg::ACC_W'(0));
    assign acc_q   = acc_rnd >>> asvs_pkg::SUM_SHIFT;

    // depth * sine / 2^15 truncated toward zero
    assign dev_rnd = prod_reg + ((prod_reg < 0)
                     ? asvs_pkg::PROD_W'((1 << asvs_pkg::DEV_SHIFT) - 1)
                     : asvs_pkg::PROD_W'(0));
    assign dev     = dev_rnd >>> asvs_pkg::DEV_SHIFT;

    always_comb
    begin
        carrier_next = carrier_reg;
        vib_next     = vib_reg;
        hphase_next  = hphase_reg;
        neg_next     = neg_reg;
        ag_next      = ag_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        sample_next  = sample_reg;
        case (cmd.op)
            asvs_pkg::OP_START:
            begin
                if (restart)
                begin
                    carrier_next = '0;
                    vib_next     = '0;
                    hphase_next  = '0;
                end
                else
                begin
                    hphase_next  = carrier_reg;
                end
                acc_next  = '0;
                prod_next = '0;
            end
            asvs_pkg::OP_HARM_ISSUE:
            begin
                neg_next    = quad[1];
                hphase_next = hphase_reg + carrier_reg;
                ag_next     = mul_p[asvs_pkg::AG_W-1:0];
                acc_next    = acc_reg + asvs_pkg::ACC_W'(prod_reg);
            end
            asvs_pkg::OP_HARM_MUL:
            begin
                prod_next = mul_p[asvs_pkg::PROD_W-1:0];
            end
            asvs_pkg::OP_ACC_LAST:
            begin
                acc_next = acc_reg + asvs_pkg::ACC_W'(prod_reg);
                vib_next = vib_reg + PB'(cfg.vib_rate);
            end
            asvs_pkg::OP_VIB_ISSUE:
            begin
                neg_next = quad[1];
                if (acc_q > asvs_pkg::SAMPLE_MAX)
                begin
                    res_next = 16'(asvs_pkg::SAMPLE_MAX);
                end
                else if (acc_q < asvs_pkg::SAMPLE_MIN)
                begin
                    res_next = 16'(asvs_pkg::SAMPLE_MIN);
                end
                else
                begin
                    res_next = acc_q[15:0];
                end
            end
            asvs_pkg::OP_VIB_MUL:
            begin
                prod_next = mul_p[asvs_pkg::PROD_W-1:0];
            end
            asvs_pkg::OP_CAR_ADV:
            begin
                carrier_next = carrier_reg + PB'(cfg.base_inc) + PB'(dev);
            end
            asvs_pkg::OP_OUT_LOAD:
            begin
                sample_next = res_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= '0;
            vib_reg     <= '0;
        end
        else
        begin
            carrier_reg <= carrier_next;
            vib_reg     <= vib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hphase_reg <= hphase_next;
        neg_reg    <= neg_next;
        ag_reg     <= ag_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

// File: rtl/asvs_ctrl.sv
// Sequencer: steps the datapath through the harmonics, vibrato and output handoff.
`default_nettype none

module asvs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire logic [3:0]           harmonic_count,
    output asvs_pkg::cmd_t            cmd
);

    asvs_pkg::state_t                  state_reg, state_next;
    logic [asvs_pkg::HIDX_W-1:0]       harm_reg, harm_next;
    logic [asvs_pkg::HCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic [asvs_pkg::HCNT_W-1:0]       cnt_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asvs_pkg::ST_IDLE;
            harm_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            harm_reg      <= harm_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (int'(harmonic_count) > asvs_pkg::MAX_HARMONICS)
        begin
            cnt_cap = asvs_pkg::HCNT_W'(asvs_pkg::MAX_HARMONICS);
        end
        else
        begin
            cnt_cap = asvs_pkg::HCNT_W'(harmonic_count);
        end

        state_next     = state_reg;
        harm_next      = harm_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = asvs_pkg::OP_NONE;
        cmd.harm_idx   = harm_reg;

        case (state_reg)
            asvs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op    = asvs_pkg::OP_START;
                    harm_next = '0;
                    cnt_next  = cnt_cap;
                    if (cnt_cap == '0)
                    begin
                        state_next = asvs_pkg::ST_H_LAST;
                    end
                    else
                    begin
                        state_next = asvs_pkg::ST_H_ISSUE;
                    end
                end
            end
            asvs_pkg::ST_H_ISSUE:
            begin
                cmd.op     = asvs_pkg::OP_HARM_ISSUE;
                state_next = asvs_pkg::ST_H_MUL;
            end
            asvs_pkg::ST_H_MUL:
            begin
                cmd.op = asvs_pkg::OP_HARM_MUL;
                if (asvs_pkg::HCNT_W'(harm_reg) + 1'b1 == cnt_reg)
                begin
                    state_next = asvs_pkg::ST_H_LAST;
                end
                else
                begin
                    harm_next  = harm_reg + 1'b1;
                    state_next = asvs_pkg::ST_H_ISSUE;
                end
            end
            asvs_pkg::ST_H_LAST:
            begin
                cmd.op     = asvs_pkg::OP_ACC_LAST;
                state_next = asvs_pkg::ST_V_ISSUE;
            end
            asvs_pkg::ST_V_ISSUE:
            begin
                cmd.op     = asvs_pkg::OP_VIB_ISSUE;
                state_next = asvs_pkg::ST_V_MUL;
            end
            asvs_pkg::ST_V_MUL:
            begin
                cmd.op     = asvs_pkg::OP_VIB_MUL;
                state_next = asvs_pkg::ST_C_ADV;
            end
            asvs_pkg::ST_C_ADV:
            begin
                cmd.op     = asvs_pkg::OP_CAR_ADV;
                state_next = asvs_pkg::ST_OUT;
            end
            asvs_pkg::ST_OUT:
            begin
                // reload only when the output register is empty or draining
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = asvs_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = asvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asvs_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != asvs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/additive_sine_vibrato_synth.sv
// Top level of the additive sine synth with vibrato: config registers, sequencer, datapath.
// Each accepted item is one sample tick; it yields one saturated signed 16-bit sample
// that sums harmonics 1..H of a sine carrier, harmonic n read at n times the carrier
// phase, each weighted by overall_amplitude and its Q1.7 gain, with the sum scaled
// down by 2^22 toward zero. A restart bit in the item clears both phases before the
// sample is formed. After each sample the vibrato phase advances by its rate and the
// carrier by base_increment plus depth times the sine of the new vibrato phase. An
// item is worked through in sequence, and the input stays stalled from its acceptance until
// its result is loaded, with H the harmonic count capped at 8: one multiplier is shared
// by the gain and sine products of every harmonic and by the vibrato deviation, and
// the quarter-wave sine ROM has a registered read. The result sits in an output
// register, so the next item is taken while it waits. Registers sit on an APB port at
// byte address 8*i (i = 0 base_increment, 1 vibrato_rate_increment, 2 vibrato_depth,
// 3 overall_amplitude, 4 harmonic_gains, 5 harmonic_count); write them only while idle.
`default_nettype none

module additive_sine_vibrato_synth (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [asvs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [asvs_pkg::APB_DW-1:0]   pwdata,
    output logic      [asvs_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    // input items
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          restart,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [15:0]                 sample
);

    logic [31:0] base_inc_reg,  base_inc_next;
    logic [31:0] vib_rate_reg,  vib_rate_next;
    logic [30:0] vib_depth_reg, vib_depth_next;
    logic [14:0] amplitude_reg, amplitude_next;
    logic [63:0] gains_reg,     gains_next;
    logic [3:0]  harm_cnt_reg,  harm_cnt_next;

    logic               wr_en;
    asvs_pkg::reg_idx_t reg_idx;
    asvs_pkg::cfg_t     cfg;
    asvs_pkg::cmd_t     cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = asvs_pkg::reg_idx_t'(paddr[asvs_pkg::APB_AW-1:3]);

    // register writes; masked to each register's width, unknown addresses ignored
    always_comb
    begin
        base_inc_next  = base_inc_reg;
        vib_rate_next  = vib_rate_reg;
        vib_depth_next = vib_depth_reg;
        amplitude_next = amplitude_reg;
        gains_next     = gains_reg;
        harm_cnt_next  = harm_cnt_reg;
        if (wr_en)
        begin
            case (reg_idx)
                asvs_pkg::REG_BASE_INC:   base_inc_next  = pwdata[31:0];
                asvs_pkg::REG_VIB_RATE:   vib_rate_next  = pwdata[31:0];
                asvs_pkg::REG_VIB_DEPTH:  vib_depth_next = pwdata[30:0];
                asvs_pkg::REG_AMPLITUDE:  amplitude_next = pwdata[14:0];
                asvs_pkg::REG_GAINS:      gains_next     = pwdata[63:0];
                asvs_pkg::REG_HARM_COUNT: harm_cnt_next  = pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_inc_reg  <= asvs_pkg::RST_BASE_INC;
            vib_rate_reg  <= asvs_pkg::RST_VIB_RATE;
            vib_depth_reg <= asvs_pkg::RST_VIB_DEPTH;
            amplitude_reg <= asvs_pkg::RST_AMPLITUDE;
            gains_reg     <= asvs_pkg::RST_GAINS;
            harm_cnt_reg  <= asvs_pkg::RST_HARM_CNT;
        end
        else
        begin
            base_inc_reg  <= base_inc_next;
            vib_rate_reg  <= vib_rate_next;
            vib_depth_reg <= vib_depth_next;
            amplitude_reg <= amplitude_next;
            gains_reg     <= gains_next;
            harm_cnt_reg  <= harm_cnt_next;
        end
    end

    // readback
    always_comb
    begin
        case (reg_idx)
            asvs_pkg::REG_BASE_INC:   prdata = 64'(base_inc_reg);
            asvs_pkg::REG_VIB_RATE:   prdata = 64'(vib_rate_reg);
            asvs_pkg::REG_VIB_DEPTH:  prdata = 64'(vib_depth_reg);
            asvs_pkg::REG_AMPLITUDE:  prdata = 64'(amplitude_reg);
            asvs_pkg::REG_GAINS:      prdata = gains_reg;
            asvs_pkg::REG_HARM_COUNT: prdata = 64'(harm_cnt_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.base_inc  = base_inc_reg;
    assign cfg.vib_rate  = vib_rate_reg;
    assign cfg.vib_depth = vib_depth_reg;
    assign cfg.amplitude = amplitude_reg;
    assign cfg.gains     = gains_reg;

    asvs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .harmonic_count (harm_cnt_reg),
        .cmd            (cmd)
    );

    asvs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .restart (restart),
        .sample  (sample)
    );

    // an accepted item always kicks off the sequence in the same cycle
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (cmd.op == asvs_pkg::OP_START))
        else $error("accepted item did not start the sequence");

    // one item at a time: input closes right after acceptance
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after acceptance");

    // a result load always presents a valid item next cycle
    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == asvs_pkg::OP_OUT_LOAD) |=> out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
